[src/mfat_pkg.sv]
// ----------------------------------------------------------------------------
// mfat_pkg
// shared types and constants of the motor feedback angle tracker
// ----------------------------------------------------------------------------
package mfat_pkg;

  localparam int SLOTS_PER_BUS = 11;
  localparam int BUS_COUNT     = 2;
  localparam int SLOT_TOTAL    = BUS_COUNT * SLOTS_PER_BUS;
  localparam int SLOT_W        = $clog2(SLOT_TOTAL);
  localparam int SLOT_ID_W     = $clog2(SLOTS_PER_BUS);
  localparam int MODEL_W       = 2 * SLOTS_PER_BUS;

  localparam logic [10:0] FIRST_ID = 11'h201;
  localparam int STEP_LIMIT  = 4096;
  localparam int TURN_SHIFT  = 13;

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MODELS_BUS0 = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MODELS_BUS1 = 1'b1;

  // geared 1:19 scaling, total * 45 / 76
  localparam int DIV_G19 = 76;
  localparam int MUL_G19 = 45;
  localparam logic [30:0] RECIP_19    = 31'd1808407283;
  localparam int          RECIP_19_SH = 35;
  localparam logic [18:0] FRAC_G19    = 19'd310434;
  localparam int          FRAC_G19_SH = 19;

  // direct drive scaling, angle * 1024 / 91
  localparam int DIV_DIRECT = 91;
  localparam logic [16:0] RECIP_91    = 17'd92183;
  localparam int          RECIP_91_SH = 23;
  localparam logic [19:0] FRAC_DIR    = 20'd737461;
  localparam int          FRAC_DIR_SH = 16;

  typedef enum logic [1:0] {
    MODEL_G19    = 2'd0,
    MODEL_G36    = 2'd1,
    MODEL_DIRECT = 2'd2,
    MODEL_NONE   = 2'd3
  } model_e;

  typedef struct packed {
    logic               bus;
    logic [10:0]        frame_id;
    logic [15:0]        angle_word;
    logic signed [15:0] speed_word;
    logic signed [15:0] current_word;
    logic [7:0]         extra_byte;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] angle_sum;
    logic signed [15:0] speed_out;
    logic signed [15:0] current_raw;
    logic [7:0]         temperature;
    logic [7:0]         hall_state;
    logic signed [31:0] rotor_degree_q8;
  } out_word_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [MODEL_W-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic        commit;
    logic        bus;
    logic [10:0] frame_id;
    logic [15:0] angle;
  } lookup_req_t;

  typedef struct packed {
    logic               hit;
    model_e             model;
    logic signed [31:0] total;
  } lookup_rsp_t;

endpackage

[src/motor_feedback_angle_tracker_core.sv]
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker_core
// multi-turn angle tracking and degree scaling of motor feedback frames
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o   in_word_i  (mfat_pkg::in_word_t)
//  out      output     out_valid_o/out_stall_i out_word_o (mfat_pkg::out_word_t)
//  cfg      input      apb psel/penable/pready paddr, pwdata, prdata
//
//  one word per cycle sustained while the output is not stalled
//  the result passes the scaling chain: reciprocal multiply, remainder, fraction
//  slot state is read from the input register and written as the word leaves it
//  reset empties the pipeline, marks all slots unregistered, clears offsets
//  a stalled output backs up the pipeline stage by stage, then the input
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mfat_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mfat_pkg::out_word_t           out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfat_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mfat_pkg::*;

  typedef struct packed {
    logic               hit;
    model_e             model;
    logic               neg;
    logic signed [31:0] total;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         extra;
  } carry_t;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic go0, go1, go2, go3, go4;

  in_word_t    s0_q;
  cfg_wr_t     cfg;
  lookup_req_t req;
  lookup_rsp_t rsp;
  logic [MODEL_W-1:0] rd_data;

  carry_t      c1_d, c1_q, c2_q, c3_q;
  logic [31:0] m1_d, m1_q, m2_q;

  logic [60:0] prod0;
  logic [32:0] prod2;
  logic [34:0] m5;
  logic [25:0] a0_2_q;
  logic [9:0]  a2_2_q;
  logic [30:0] q1_2_q, q1_3_q;

  logic [6:0]  b0_3_d, b0_3_q;
  logic [31:0] p0_3_q;
  logic [6:0]  b2_3_d, b2_3_q;
  logic [19:0] p2_3_q;

  logic [25:0] fr0;
  logic [26:0] fr2;
  logic [31:0] mag;
  out_word_t   out_d, out_q;

  // pipeline flow
  assign go4 = !v4_q || !out_stall_i;
  assign go3 = !v3_q || go4;
  assign go2 = !v2_q || go3;
  assign go1 = !v1_q || go2;
  assign go0 = !v0_q || go1;
  assign in_stall_o = !go0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (go0) v0_q <= in_valid_i;
      if (go1) v1_q <= v0_q;
      if (go2) v2_q <= v1_q;
      if (go3) v3_q <= v2_q;
      if (go4) v4_q <= v3_q;
    end
  end

  // configuration port
  assign pready  = 1'b1;
  assign cfg.we   = psel && penable && pwrite;
  assign cfg.idx  = paddr[2 +: REG_IDX_W];
  assign cfg.data = pwdata[MODEL_W-1:0];
  assign prdata   = 32'(rd_data);

  assign req.commit   = v0_q && go1;
  assign req.bus      = s0_q.bus;
  assign req.frame_id = s0_q.frame_id;
  assign req.angle    = s0_q.angle_word;

  mfat_slot_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .rd_idx_i  (paddr[2 +: REG_IDX_W]),
    .rd_data_o (rd_data),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  // stage 1: slot state applied
  assign c1_d.hit     = rsp.hit;
  assign c1_d.model   = rsp.model;
  assign c1_d.neg     = rsp.total[31];
  assign c1_d.total   = rsp.total;
  assign c1_d.angle   = s0_q.angle_word;
  assign c1_d.speed   = s0_q.speed_word;
  assign c1_d.current = s0_q.current_word;
  assign c1_d.extra   = s0_q.extra_byte;
  assign m1_d = rsp.total[31] ? $unsigned(-rsp.total) : $unsigned(rsp.total);

  // stage 2: quotients by reciprocal
  assign prod0 = 61'(m1_q[31:2]) * 61'(RECIP_19);
  assign prod2 = 33'(c1_q.angle) * 33'(RECIP_91);
  assign m5    = (35'(m1_q) << 2) + 35'(m1_q);

  // stage 3: remainders
  assign b0_3_d = 7'(m2_q - 32'(a0_2_q) * 32'(DIV_G19));
  assign b2_3_d = 7'(c2_q.angle - 16'(a2_2_q) * 16'(DIV_DIRECT));

  // stage 4: fractional parts and sign
  assign fr0 = 26'(b0_3_q) * 26'(FRAC_G19);
  assign fr2 = 27'(b2_3_q) * 27'(FRAC_DIR);

  always_comb begin
    case (c3_q.model)
      MODEL_G19:    mag = p0_3_q + 32'(fr0[25:FRAC_G19_SH]);
      MODEL_G36:    mag = 32'(q1_3_q);
      MODEL_DIRECT: mag = 32'(p2_3_q) + 32'(fr2[25:FRAC_DIR_SH]);
      default:      mag = '0;
    endcase
  end

  always_comb begin
    out_d = '0;
    if (c3_q.hit) begin
      out_d.accepted    = 1'b1;
      out_d.angle_sum   = c3_q.total;
      out_d.speed_out   = c3_q.speed;
      out_d.current_raw = c3_q.current;
      out_d.temperature = (c3_q.model == MODEL_DIRECT) ? c3_q.extra : 8'd0;
      out_d.hall_state  = c3_q.extra;
      out_d.rotor_degree_q8 = (c3_q.neg && (c3_q.model != MODEL_DIRECT))
                              ? -$signed(mag) : $signed(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go0) begin
      s0_q <= in_word_i;
    end
    if (go1) begin
      c1_q <= c1_d;
      m1_q <= m1_d;
    end
    if (go2) begin
      c2_q   <= c1_q;
      m2_q   <= m1_q;
      a0_2_q <= prod0[60:RECIP_19_SH];
      a2_2_q <= prod2[32:RECIP_91_SH];
      q1_2_q <= m5[34:4];
    end
    if (go3) begin
      c3_q   <= c2_q;
      b0_3_q <= b0_3_d;
      p0_3_q <= 32'(a0_2_q) * 32'(MUL_G19);
      b2_3_q <= b2_3_d;
      p2_3_q <= {a2_2_q, 10'b0};
      q1_3_q <= q1_2_q;
    end
    if (go4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side can move");

  a_ignored_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.accepted |-> out_word_o == '0)
    else $error("ignored frame result carries nonzero fields");
`endif

endmodule

[src/mfat_slot_state.sv]
// ----------------------------------------------------------------------------
// mfat_slot_state
// per-slot turn tracking state and model map registers
// ----------------------------------------------------------------------------
module mfat_slot_state (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfat_pkg::cfg_wr_t            cfg_i,
  input  logic [mfat_pkg::REG_IDX_W-1:0] rd_idx_i,
  output logic [mfat_pkg::MODEL_W-1:0] rd_data_o,
  input  mfat_pkg::lookup_req_t        req_i,
  output mfat_pkg::lookup_rsp_t        rsp_o
);
  import mfat_pkg::*;

  logic [MODEL_W-1:0]    models_q [BUS_COUNT];
  logic [SLOT_TOTAL-1:0] valid_q;
  logic [15:0]           last_q   [SLOT_TOTAL];
  logic [15:0]           offset_q [SLOT_TOTAL];
  logic [31:0]           turns_q  [SLOT_TOTAL];

  logic [10:0]          id_off;
  logic                 in_range;
  logic [SLOT_ID_W-1:0] slot;
  logic [SLOT_W-1:0]    idx;
  model_e               model;
  logic                 hit;
  logic                 wr_en;
  logic [15:0]          base_last;
  logic [15:0]          base_off;
  logic [31:0]          base_turns;
  logic [31:0]          turns_d;
  logic signed [16:0]   diff;

  assign id_off   = req_i.frame_id - FIRST_ID;
  assign in_range = (req_i.frame_id >= FIRST_ID) && (id_off < 11'(SLOTS_PER_BUS));
  assign slot     = id_off[SLOT_ID_W-1:0];
  assign idx      = SLOT_W'(int'(req_i.bus) * SLOTS_PER_BUS + int'(slot));
  assign model    = model_e'(models_q[req_i.bus][{slot, 1'b0} +: 2]);
  assign hit      = in_range && (model != MODEL_NONE);
  assign wr_en    = req_i.commit && hit;

  // first word of a slot captures the offset
  assign base_last  = valid_q[idx] ? last_q[idx]   : req_i.angle;
  assign base_off   = valid_q[idx] ? offset_q[idx] : req_i.angle;
  assign base_turns = valid_q[idx] ? turns_q[idx]  : 32'd0;

  assign diff = $signed({1'b0, req_i.angle}) - $signed({1'b0, base_last});

  always_comb begin
    turns_d = base_turns;
    if (diff > $signed(17'(STEP_LIMIT))) begin
      turns_d = base_turns - 32'd1;
    end else if (diff < -$signed(17'(STEP_LIMIT))) begin
      turns_d = base_turns + 32'd1;
    end
  end

  assign rsp_o.hit   = hit;
  assign rsp_o.model = model;
  assign rsp_o.total = $signed({turns_d[31-TURN_SHIFT:0], {TURN_SHIFT{1'b0}}}
                               + 32'(req_i.angle) - 32'(base_off));

  assign rd_data_o = models_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUS_COUNT; b++) begin
        models_q[b] <= '1;
      end
      valid_q <= '0;
    end else begin
      if (wr_en) begin
        valid_q[idx] <= 1'b1;
      end
      if (cfg_i.we) begin
        models_q[cfg_i.idx] <= cfg_i.data;
        for (int b = 0; b < BUS_COUNT; b++) begin
          if (cfg_i.idx == REG_IDX_W'(b)) begin
            valid_q[b*SLOTS_PER_BUS +: SLOTS_PER_BUS] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      last_q[idx]   <= req_i.angle;
      offset_q[idx] <= base_off;
      turns_q[idx]  <= turns_d;
    end
  end

`ifndef SYNTHESIS
  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !cfg_i.we |=> valid_q[$past(idx)])
    else $error("slot not marked valid after update");

  a_cfg0_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.we && (cfg_i.idx == REG_MODELS_BUS0) |=> valid_q[SLOTS_PER_BUS-1:0] == '0)
    else $error("bus 0 offsets not cleared by model write");

  a_cfg1_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.we && (cfg_i.idx == REG_MODELS_BUS1)
    |=> valid_q[2*SLOTS_PER_BUS-1 -: SLOTS_PER_BUS] == '0)
    else $error("bus 1 offsets not cleared by model write");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for motor_feedback_angle_tracker_core: frames go in
// through a queue-fed driver, every result word is checked against a
// per-slot turn tracker kept in the bench, over several model maps
// ----------------------------------------------------------------------------
module tb_top;
  import mfat_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 310;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 frame_valid = 1'b0;
  logic                 frame_stall;
  in_word_t             frame_word = '0;
  logic                 fb_valid;
  logic                 fb_stall = 1'b0;
  out_word_t            fb_word;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  motor_feedback_angle_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_valid),
    .in_stall_o  (frame_stall),
    .in_word_i   (frame_word),
    .out_valid_o (fb_valid),
    .out_stall_i (fb_stall),
    .out_word_o  (fb_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  in_word_t    pending_frames[$];
  out_word_t   predicted_feedback[$];

  logic [MODEL_W-1:0] model_map [BUS_COUNT];
  logic [15:0]        last_seen [SLOT_TOTAL];
  logic [15:0]        base_angle[SLOT_TOTAL];
  logic [31:0]        turns_q   [SLOT_TOTAL];
  bit                 captured  [SLOT_TOTAL];
  logic [15:0]        gen_angle [SLOT_TOTAL];

  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  holds_requested = 0;
  int  holds_started = 0;
  bit  calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_word_t track_frame(in_word_t w);
    out_word_t   r;
    int          slot_id;
    int          k;
    int          diff;
    model_e      m;
    logic [31:0] turns;
    logic [31:0] total;
    longint      deg;
    r = '0;
    slot_id = int'(w.frame_id) - int'(FIRST_ID);
    if (slot_id < 0 || slot_id >= SLOTS_PER_BUS) return r;
    m = model_e'(model_map[w.bus][2*slot_id +: 2]);
    if (m == MODEL_NONE) return r;
    k = int'(w.bus) * SLOTS_PER_BUS + slot_id;
    if (!captured[k]) begin
      base_angle[k] = w.angle_word;
      last_seen[k]  = w.angle_word;
      turns_q[k]    = '0;
      captured[k]   = 1'b1;
    end
    diff  = int'(w.angle_word) - int'(last_seen[k]);
    turns = turns_q[k];
    if (diff > STEP_LIMIT) turns = turns - 32'd1;
    else if (diff < -STEP_LIMIT) turns = turns + 32'd1;
    turns_q[k]   = turns;
    last_seen[k] = w.angle_word;
    total = (turns << TURN_SHIFT) + {16'h0, w.angle_word} - {16'h0, base_angle[k]};
    case (m)
      MODEL_G19: deg = longint'($signed(total)) * MUL_G19 / DIV_G19;
      MODEL_G36: deg = longint'($signed(total)) * 5 / 16;
      default:   deg = longint'(w.angle_word) * 1024 / DIV_DIRECT;
    endcase
    r.accepted        = 1'b1;
    r.angle_sum       = total;
    r.speed_out       = w.speed_word;
    r.current_raw     = w.current_word;
    r.temperature     = (m == MODEL_DIRECT) ? w.extra_byte : 8'h00;
    r.hall_state      = w.extra_byte;
    r.rotor_degree_q8 = deg[31:0];
    return r;
  endfunction

  function automatic in_word_t random_frame();
    in_word_t w;
    int       kind;
    int       k;
    int       step;
    bit       in_range;
    w.bus          = 1'($urandom_range(0, 1));
    w.speed_word   = 16'($urandom);
    w.current_word = 16'($urandom);
    w.extra_byte   = 8'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 12) w.frame_id = 11'($urandom);
    else if (kind < 16) w.frame_id = ($urandom_range(0, 1) == 0) ? FIRST_ID - 11'd1 :
                                     FIRST_ID + 11'(SLOTS_PER_BUS + $urandom_range(0, 4));
    else w.frame_id = FIRST_ID + 11'($urandom_range(0, SLOTS_PER_BUS - 1));
    k = int'(w.frame_id) - int'(FIRST_ID);
    in_range = (k >= 0 && k < SLOTS_PER_BUS);
    if (!in_range) k = 0;
    k = k + int'(w.bus) * SLOTS_PER_BUS;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      step = $urandom_range(0, 1200) - 600;
      w.angle_word = 16'((int'(gen_angle[k]) + step + 8192) % 8192);
    end else if (kind < 8) begin
      w.angle_word = 16'($urandom);
    end else begin
      step = $urandom_range(STEP_LIMIT - 1, STEP_LIMIT + 1);
      w.angle_word = ($urandom_range(0, 1) == 0) ? gen_angle[k] + 16'(step) :
                                                   gen_angle[k] - 16'(step);
    end
    gen_angle[k] = w.angle_word;
    return w;
  endfunction

  task automatic queue_frame(input logic bus, input logic [10:0] id, input logic [15:0] angle,
                             input logic [15:0] speed, input logic [15:0] current,
                             input logic [7:0] extra);
    in_word_t w;
    w.bus          = bus;
    w.frame_id     = id;
    w.angle_word   = angle;
    w.speed_word   = speed;
    w.current_word = current;
    w.extra_byte   = extra;
    pending_frames.push_back(w);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      pending_frames.push_back(random_frame());
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_frames.size() != 0 || frame_valid || predicted_feedback.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_models(input logic [REG_IDX_W-1:0] idx, input logic [MODEL_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {10'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    model_map[idx] = value;
    for (int s = 0; s < SLOTS_PER_BUS; s++) captured[int'(idx) * SLOTS_PER_BUS + s] = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // frame driver
  always @(posedge clk_i) begin : drive_frames
    logic     nxt_valid;
    in_word_t nxt_word;
    if (rst_ni) begin
      nxt_valid = frame_valid;
      nxt_word  = frame_word;
      if (frame_valid && !frame_stall) begin
        predicted_feedback.push_back(track_frame(frame_word));
        nxt_valid = 1'b0;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_frames.size() > 0) begin
          nxt_word  = pending_frames.pop_front();
          nxt_valid = 1'b1;
        end
      end
      frame_valid <= nxt_valid;
      frame_word  <= nxt_word;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch_feedback
    logic      nxt_stall;
    out_word_t exp_w;
    if (rst_ni) begin
      if (fb_valid && !fb_stall) begin
        if (predicted_feedback.size() == 0) begin
          $error("result word with nothing pending");
          errors++;
        end else begin
          exp_w = predicted_feedback.pop_front();
          check_field("accepted", 32'(exp_w.accepted), 32'(fb_word.accepted));
          check_field("angle_sum", exp_w.angle_sum, fb_word.angle_sum);
          check_field("speed_out", 32'(exp_w.speed_out), 32'(fb_word.speed_out));
          check_field("current_raw", 32'(exp_w.current_raw), 32'(fb_word.current_raw));
          check_field("temperature", 32'(exp_w.temperature), 32'(fb_word.temperature));
          check_field("hall_state", 32'(exp_w.hall_state), 32'(fb_word.hall_state));
          check_field("rotor_degree_q8", exp_w.rotor_degree_q8, fb_word.rotor_degree_q8);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (holds_started < holds_requested) begin
        holds_started++;
        hold_left = LONG_HOLD - 1;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
      end
      fb_stall <= nxt_stall;
    end
  end

  initial begin
    logic [MODEL_W-1:0] map0;
    logic [MODEL_W-1:0] map1;
    for (int b = 0; b < BUS_COUNT; b++) model_map[b] = '1;
    for (int k = 0; k < SLOT_TOTAL; k++) begin
      last_seen[k]  = '0;
      base_angle[k] = '0;
      turns_q[k]    = '0;
      captured[k]   = 1'b0;
      gen_angle[k]  = 16'($urandom_range(0, 8191));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every slot unregistered after reset
    queue_frame(1'b0, FIRST_ID, 16'd10, 16'sd5, 16'sd6, 8'd7);
    queue_frame(1'b1, FIRST_ID + 11'd3, 16'd20, 16'sd1, 16'sd2, 8'd3);
    wait_idle();

    // slot 0 geared 1:19, slot 1 geared 1:36, slot 2 direct, slot 3 unregistered
    write_models(REG_MODELS_BUS0, 22'h0000E4);
    write_models(REG_MODELS_BUS1, 22'h2AAAAA);
    @(negedge clk_i);
    queue_frame(1'b0, 11'h000, 16'd1, 16'sd1, 16'sd1, 8'd1);
    queue_frame(1'b0, FIRST_ID - 11'd1, 16'd1, 16'sd1, 16'sd1, 8'd1);
    queue_frame(1'b0, FIRST_ID + 11'd11, 16'd1, 16'sd1, 16'sd1, 8'd1);
    queue_frame(1'b0, 11'h7FF, 16'hFFFF, 16'sd1, 16'sd1, 8'd1);
    queue_frame(1'b0, FIRST_ID + 11'd3, 16'd500, 16'sd9, 16'sd9, 8'd9);
    queue_frame(1'b0, FIRST_ID, 16'd100, 16'sd10, -16'sd10, 8'd1);
    queue_frame(1'b0, FIRST_ID, 16'd8000, 16'sd20, -16'sd20, 8'd2);
    queue_frame(1'b0, FIRST_ID, 16'd50, 16'sd30, -16'sd30, 8'd3);
    queue_frame(1'b0, FIRST_ID, 16'd4196, 16'sd40, -16'sd40, 8'd4);
    queue_frame(1'b0, FIRST_ID, 16'd100, 16'sd50, -16'sd50, 8'd5);
    queue_frame(1'b0, FIRST_ID, 16'd4196, 16'sd50, -16'sd50, 8'd5);
    queue_frame(1'b0, FIRST_ID, 16'hFFFF, 16'sh7FFF, 16'sh8000, 8'hFF);
    queue_frame(1'b0, FIRST_ID, 16'h0000, 16'sh8000, 16'sh7FFF, 8'h00);
    queue_frame(1'b0, FIRST_ID + 11'd1, 16'd0, -16'sd1, 16'sd1, 8'hA5);
    queue_frame(1'b0, FIRST_ID + 11'd1, 16'd8191, 16'sd100, 16'sd200, 8'h5A);
    queue_frame(1'b0, FIRST_ID + 11'd1, 16'd0, 16'sd100, 16'sd200, 8'h5A);
    queue_frame(1'b0, FIRST_ID + 11'd2, 16'hFFFF, 16'sh8000, 16'sh7FFF, 8'hFF);
    queue_frame(1'b0, FIRST_ID + 11'd2, 16'h0000, 16'sh7FFF, 16'sh8000, 8'h00);
    queue_frame(1'b1, FIRST_ID + 11'd10, 16'd1234, 16'sd77, -16'sd77, 8'h3C);
    queue_frame(1'b1, FIRST_ID + 11'd10, 16'd9000, 16'sd77, -16'sd77, 8'hC3);
    queue_frame(1'b1, FIRST_ID + 11'd11, 16'd1234, 16'sd1, 16'sd1, 8'h01);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin map0 = '0; map1 = '0; end
        1: begin map0 = 22'h155555; map1 = 22'h2AAAAA; end
        3: begin map0 = '1; map1 = 22'($urandom); end
        4: begin map0 = 22'($urandom); map1 = 22'h155555; end
        default: begin map0 = 22'($urandom); map1 = 22'($urandom); end
      endcase
      write_models(REG_MODELS_BUS0, map0);
      write_models(REG_MODELS_BUS1, map1);
      @(negedge clk_i);
      if (phase == 5) calm = 1'b1;
      if (phase == 1) holds_requested++;
      if (phase == 2) begin
        queue_random(PHASE_ITEMS / 2);
        wait_idle();
        queue_random(PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    if (predicted_feedback.size() != 0) begin
      $error("results still pending at end: %0d", predicted_feedback.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
